[rtl/core/rhp_pkg.sv]
// shared types and constants for the rgb to hsv pixel converter
package rhp_pkg;

  localparam int CB     = 8;                  // bits per color component
  localparam int QB     = (CB > 10) ? CB : 10; // quotient bits, one per divider cell
  localparam int W      = CB + QB + 1;        // partial remainder width
  localparam int HUE_W  = 13;

  localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(1920);
  localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(3840);
  localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(5760);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // one running restoring division
  typedef struct packed {
    logic [W-1:0]  rem;
    logic [W-1:0]  dvs;
    logic [QB-1:0] quo;
  } lane_t;

  // per-pixel sideband carried along the chain
  typedef struct packed {
    logic          valid;
    logic          grey;
    sector_t       sector;
    logic          neg;
    logic [CB-1:0] val;
    logic [CB-1:0] alpha;
  } side_t;

endpackage

[rtl/core/rhp_front.sv]
// input stage: max, min, delta, sector and the two dividends
module rhp_front import rhp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [CB-1:0] red_in,
  input  logic [CB-1:0] green_in,
  input  logic [CB-1:0] blue_in,
  input  logic [CB-1:0] alpha_in,
  output side_t         side,
  output lane_t         hue_lane,
  output lane_t         sat_lane
);

  logic [CB-1:0] mx, mn, delta, span;
  side_t         side_next;
  lane_t         hue_next, sat_next;

  always_comb begin
    mx = (red_in > green_in) ? red_in : green_in;
    mx = (mx > blue_in) ? mx : blue_in;
    mn = (red_in < green_in) ? red_in : green_in;
    mn = (mn < blue_in) ? mn : blue_in;
    delta = mx - mn;

    side_next.valid = take && !rst;
    side_next.grey  = (delta == '0);
    side_next.val   = mx;
    side_next.alpha = alpha_in;

    // ties: red over green over blue
    if (red_in >= mx) begin
      side_next.sector = SEC_RED;
      side_next.neg    = green_in < blue_in;
      span = side_next.neg ? (blue_in - green_in) : (green_in - blue_in);
    end else if (green_in >= mx) begin
      side_next.sector = SEC_GREEN;
      side_next.neg    = red_in > blue_in;
      span = side_next.neg ? (red_in - blue_in) : (blue_in - red_in);
    end else begin
      side_next.sector = SEC_BLUE;
      side_next.neg    = green_in > red_in;
      span = side_next.neg ? (green_in - red_in) : (red_in - green_in);
    end

    // 960*span and full*delta by shift and subtract
    hue_next.rem = (W'(span) << 10) - (W'(span) << 6);
    hue_next.dvs = W'(delta) << (QB - 1);
    hue_next.quo = '0;
    sat_next.rem = (W'(delta) << CB) - W'(delta);
    sat_next.dvs = W'(mx) << (QB - 1);
    sat_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    side     <= side_next;
    hue_lane <= hue_next;
    sat_lane <= sat_next;
  end

endmodule

[rtl/core/rhp_div_cell.sv]
// one divider cell: a quotient bit for the hue and the saturation division
module rhp_div_cell import rhp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  side_t side_in,
  input  lane_t hue_in,
  input  lane_t sat_in,
  output side_t side_out,
  output lane_t hue_out,
  output lane_t sat_out
);

  side_t side_next;
  lane_t hue_next, sat_next;

  function automatic lane_t div_step(lane_t x);
    lane_t y;
    y = x;
    if (x.rem >= x.dvs) begin
      y.rem = x.rem - x.dvs;
      y.quo = {x.quo[QB-2:0], 1'b1};
    end else begin
      y.quo = {x.quo[QB-2:0], 1'b0};
    end
    y.dvs = x.dvs >> 1;
    return y;
  endfunction

  always_comb begin
    side_next       = side_in;
    side_next.valid = side_in.valid && !rst;
    hue_next        = div_step(hue_in);
    sat_next        = div_step(sat_in);
  end

  always_ff @(posedge clk) begin
    side_out <= side_next;
    hue_out  <= hue_next;
    sat_out  <= sat_next;
  end

endmodule

[rtl/core/rhp_back.sv]
// output stage: sector offset, floor of negative hue, wrap and grey override
module rhp_back import rhp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  side_t            side,
  input  lane_t            hue_lane,
  input  lane_t            sat_lane,
  output logic             done,
  output logic [HUE_W-1:0] hue_out,
  output logic [CB-1:0]    sat_out,
  output logic [CB-1:0]    val_out,
  output logic [CB-1:0]    alpha_out
);

  logic [HUE_W-1:0] step, base, hue_next;
  logic [CB-1:0]    sat_next;

  always_comb begin
    // floor rounds a negative fraction away from zero
    step = HUE_W'(hue_lane.quo) + HUE_W'(side.neg && (hue_lane.rem != '0));
    case (side.sector)
      SEC_RED:   base = side.neg ? HUE_FULL : '0;
      SEC_GREEN: base = HUE_GREEN;
      SEC_BLUE:  base = HUE_BLUE;
      default:   base = '0;
    endcase
    hue_next = side.neg ? (base - step) : (base + step);
    sat_next = sat_lane.quo[CB-1:0];
    if (side.grey) begin
      hue_next = '0;
      sat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid;
    end
    hue_out   <= hue_next;
    sat_out   <= sat_next;
    val_out   <= side.val;
    alpha_out <= side.alpha;
  end

endmodule

[rtl/core/rgb_to_hsv_pixel_unit.sv]
// top level of the rgb to hsv pixel converter
// Takes one pixel per clock and never raises busy. Each result passes
// through one input stage, a chain of QB divider cells that each resolve
// one quotient bit of the hue and saturation divisions, and one output
// stage, each registered. done marks each result for exactly one cycle;
// results leave in input order and the receiver cannot stall them.
module rgb_to_hsv_pixel_unit import rhp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CB-1:0]    red_in,
  input  logic [CB-1:0]    green_in,
  input  logic [CB-1:0]    blue_in,
  input  logic [CB-1:0]    alpha_in,
  output logic             done,
  output logic [HUE_W-1:0] hue_out,
  output logic [CB-1:0]    sat_out,
  output logic [CB-1:0]    val_out,
  output logic [CB-1:0]    alpha_out
);

  side_t side [QB+1];
  lane_t hue  [QB+1];
  lane_t sat  [QB+1];

  assign busy = 1'b0;

  rhp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (start),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .alpha_in (alpha_in),
    .side     (side[0]),
    .hue_lane (hue[0]),
    .sat_lane (sat[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    rhp_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side[i]),
      .hue_in   (hue[i]),
      .sat_in   (sat[i]),
      .side_out (side[i+1]),
      .hue_out  (hue[i+1]),
      .sat_out  (sat[i+1])
    );
  end

  rhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .side      (side[QB]),
    .hue_lane  (hue[QB]),
    .sat_lane  (sat[QB]),
    .done      (done),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out),
    .alpha_out (alpha_out)
  );

endmodule
